### design/kvd_pkg.sv
// Shared types, constants and key decoding for the keypad debounce and value entry block.
package kvd_pkg;

    localparam logic [4:0]  KEY_NONE        = 5'd16;

    localparam logic [3:0]  FN_DIGIT_MAX    = 4'd9;
    localparam logic [3:0]  FN_A            = 4'd10;
    localparam logic [3:0]  FN_B            = 4'd11;
    localparam logic [3:0]  FN_C            = 4'd12;
    localparam logic [3:0]  FN_D            = 4'd13;
    localparam logic [3:0]  FN_STAR         = 4'd14;
    localparam logic [3:0]  FN_HASH         = 4'd15;

    localparam logic [1:0]  CFG_DEBOUNCE    = 2'd0;
    localparam logic [1:0]  CFG_CUTOFF_MIN  = 2'd1;
    localparam logic [1:0]  CFG_CUTOFF_MAX  = 2'd2;
    localparam logic [1:0]  CFG_MODE_COUNT  = 2'd3;

    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd5;
    localparam logic [11:0] CUTOFF_MIN_RESET = 12'd1;
    localparam logic [11:0] CUTOFF_MAX_RESET = 12'd2000;
    localparam logic [3:0]  MODE_COUNT_RESET = 4'd7;
    localparam logic [11:0] CUTOFF_RESET    = 12'd100;
    localparam logic [3:0]  MODE_COUNT_MAX  = 4'd8;
    localparam logic [13:0] ENTRY_VALUE_MAX = 14'h3FFF;

    localparam bit          CMD_MODE        = 1'b0;
    localparam bit          CMD_CUTOFF      = 1'b1;

    typedef enum logic {
        UI_IDLE,
        UI_SET
    } t_ui_state;

    typedef struct packed {
        logic       press;
        logic [3:0] key;
    } t_event;

    typedef struct packed {
        logic [11:0] cutoff_min;
        logic [11:0] cutoff_max;
        logic [3:0]  mode_count;
    } t_back_cfg;

    typedef struct packed {
        logic        press_valid;
        logic [3:0]  press_key;
        logic        cmd_valid;
        logic        cmd_kind;
        logic [11:0] cmd_value;
        logic        in_set_state;
        logic [2:0]  filter_mode;
        logic [11:0] cutoff_hz;
        logic [2:0]  entry_len;
        logic [13:0] entry_value;
    } t_result;

    // Key index (row*4+column) to its legend: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
    function automatic logic [3:0] key_fn(input logic [3:0] key);
        logic [3:0] fn;
        case (key)
            4'd0:    fn = 4'd1;
            4'd1:    fn = 4'd2;
            4'd2:    fn = 4'd3;
            4'd3:    fn = FN_A;
            4'd4:    fn = 4'd4;
            4'd5:    fn = 4'd5;
            4'd6:    fn = 4'd6;
            4'd7:    fn = FN_B;
            4'd8:    fn = 4'd7;
            4'd9:    fn = 4'd8;
            4'd10:   fn = 4'd9;
            4'd11:   fn = FN_C;
            4'd12:   fn = FN_STAR;
            4'd13:   fn = 4'd0;
            4'd14:   fn = FN_HASH;
            default: fn = FN_D;
        endcase
        return fn;
    endfunction

    // Remainder of a value of at most eight by a divisor of one to eight.
    function automatic logic [3:0] small_mod(input logic [3:0] v, input logic [3:0] n);
        logic [3:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r;
    endfunction

endpackage

### design/kvd_queue.sv
// Two-entry first-in first-out queue used between the front, the back and the result port.
module kvd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue occupancy beyond two");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into a full queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue occupancy did not follow a push");

endmodule

### design/kvd_front.sv
// Debounce front end: turns each scan tick into a press event for the entry machine.
module kvd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [4:0]    i_raw_key,
    input  logic [7:0]    i_debounce,
    output kvd_pkg::t_event o_event
);

    logic [4:0] r_last;
    logic [4:0] r_stable;
    logic [7:0] r_cnt;
    logic [4:0] n_last;
    logic [4:0] n_stable;
    logic [7:0] n_cnt;
    logic [4:0] raw;
    logic       press;

    // Codes above the no-key value are treated as no key.
    assign raw = (i_raw_key > kvd_pkg::KEY_NONE) ? kvd_pkg::KEY_NONE : i_raw_key;

    always_comb begin
        n_last   = r_last;
        n_stable = r_stable;
        n_cnt    = r_cnt;
        press    = 1'b0;
        if (raw == r_last) begin
            if (r_cnt != 8'hFF) begin
                n_cnt = r_cnt + 8'd1;
            end
        end else begin
            n_last = raw;
            n_cnt  = 8'd0;
        end
        // Once the run is long enough the count is pulled back to the setting.
        if (n_cnt >= i_debounce) begin
            if (raw != r_stable) begin
                n_stable = raw;
                press    = (raw != kvd_pkg::KEY_NONE);
            end
            n_cnt = i_debounce;
        end
        o_event.press = press;
        o_event.key   = press ? raw[3:0] : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= kvd_pkg::KEY_NONE;
            r_stable <= kvd_pkg::KEY_NONE;
            r_cnt    <= 8'd0;
        end else if (i_accept) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
        end
    end

endmodule

### design/kvd_back.sv
// Entry machine back end: applies press events to the mode, cutoff and digit entry state.
module kvd_back #(
    parameter int ENTRY_DIGITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ev_valid,
    input  kvd_pkg::t_event    i_event,
    input  logic               i_out_ready,
    input  kvd_pkg::t_back_cfg i_cfg,
    output logic               o_ev_pop,
    output logic               o_res_push,
    output kvd_pkg::t_result   o_result
);

    localparam int CW = $clog2(ENTRY_DIGITS + 1);
    localparam int IW = (ENTRY_DIGITS > 1) ? $clog2(ENTRY_DIGITS) : 1;
    localparam int PW = $clog2(10 ** ENTRY_DIGITS);
    localparam int VW = (PW > 12) ? PW : 12;
    localparam int SW = (PW > 14) ? PW : 14;

    kvd_pkg::t_ui_state r_ui;
    kvd_pkg::t_ui_state n_ui;
    logic [2:0]         r_mode;
    logic [2:0]         n_mode;
    logic [11:0]        r_cutoff;
    logic [11:0]        n_cutoff;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [PW-1:0]      r_cur;
    logic [PW-1:0]      n_cur;
    // Entry i holds the decimal value of the first i+1 digits.
    logic [PW-1:0]      r_prefix [ENTRY_DIGITS];

    logic               step;
    logic [3:0]         fn;
    logic [CW-1:0]      cnt_m2;
    logic [PW-1:0]      prev_val;
    logic [PW-1:0]      appended;
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    logic [3:0]         mode_n;
    logic [3:0]         mode_next;
    logic [VW-1:0]      clamp_v;
    logic [SW-1:0]      ev_ext;
    logic               cmd_valid;
    logic               cmd_kind;
    logic [11:0]        cmd_value;

    assign step       = i_ev_valid && i_out_ready;
    assign o_ev_pop   = step;
    assign o_res_push = step;
    assign fn         = kvd_pkg::key_fn(i_event.key);
    assign cnt_m2     = r_count - CW'(2);
    assign prev_val   = r_prefix[cnt_m2[IW-1:0]];
    assign appended   = PW'({r_cur, 3'b000}) + PW'({r_cur, 1'b0}) + PW'(fn);
    assign wr_idx     = r_count[IW-1:0];
    assign mode_next  = kvd_pkg::small_mod({1'b0, r_mode} + 4'd1, mode_n);

    always_comb begin
        if (i_cfg.mode_count == 4'd0) begin
            mode_n = 4'd1;
        end else if (i_cfg.mode_count > kvd_pkg::MODE_COUNT_MAX) begin
            mode_n = kvd_pkg::MODE_COUNT_MAX;
        end else begin
            mode_n = i_cfg.mode_count;
        end
        // Minimum first, then maximum, so a crossed pair gives the maximum.
        clamp_v = VW'(r_cur);
        if (clamp_v < VW'(i_cfg.cutoff_min)) begin
            clamp_v = VW'(i_cfg.cutoff_min);
        end
        if (clamp_v > VW'(i_cfg.cutoff_max)) begin
            clamp_v = VW'(i_cfg.cutoff_max);
        end
    end

    always_comb begin
        n_ui      = r_ui;
        n_mode    = r_mode;
        n_cutoff  = r_cutoff;
        n_count   = r_count;
        n_cur     = r_cur;
        wr_en     = 1'b0;
        cmd_valid = 1'b0;
        cmd_kind  = kvd_pkg::CMD_MODE;
        cmd_value = 12'd0;
        if (step && i_event.press) begin
            case (r_ui)
                kvd_pkg::UI_IDLE: begin
                    if (fn == kvd_pkg::FN_A) begin
                        n_mode    = mode_next[2:0];
                        cmd_valid = 1'b1;
                        cmd_kind  = kvd_pkg::CMD_MODE;
                        cmd_value = {9'd0, n_mode};
                    end else if (fn == kvd_pkg::FN_B) begin
                        n_ui    = kvd_pkg::UI_SET;
                        n_count = '0;
                        n_cur   = '0;
                    end
                end
                kvd_pkg::UI_SET: begin
                    if (fn inside {[4'd0:kvd_pkg::FN_DIGIT_MAX]}) begin
                        if (r_count < CW'(ENTRY_DIGITS)) begin
                            wr_en   = 1'b1;
                            n_cur   = appended;
                            n_count = r_count + CW'(1);
                        end
                    end else if (fn == kvd_pkg::FN_STAR) begin
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                            n_cur   = (r_count >= CW'(2)) ? prev_val : '0;
                        end
                    end else if (fn == kvd_pkg::FN_HASH) begin
                        if (r_count != '0) begin
                            n_cutoff  = clamp_v[11:0];
                            cmd_valid = 1'b1;
                            cmd_kind  = kvd_pkg::CMD_CUTOFF;
                            cmd_value = clamp_v[11:0];
                        end
                        n_ui = kvd_pkg::UI_IDLE;
                    end else if (fn == kvd_pkg::FN_D || fn == kvd_pkg::FN_B) begin
                        n_ui = kvd_pkg::UI_IDLE;
                    end
                end
                default: begin
                    n_ui = kvd_pkg::UI_IDLE;
                end
            endcase
        end
        ev_ext = SW'(n_cur);
        o_result.press_valid  = i_event.press;
        o_result.press_key    = i_event.key;
        o_result.cmd_valid    = cmd_valid;
        o_result.cmd_kind     = cmd_kind;
        o_result.cmd_value    = cmd_value;
        o_result.in_set_state = (n_ui == kvd_pkg::UI_SET);
        o_result.filter_mode  = n_mode;
        o_result.cutoff_hz    = n_cutoff;
        o_result.entry_len    = 3'(n_count);
        o_result.entry_value  = (ev_ext > SW'(kvd_pkg::ENTRY_VALUE_MAX)) ?
                                kvd_pkg::ENTRY_VALUE_MAX : ev_ext[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_prefix[wr_idx] <= appended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ui     <= kvd_pkg::UI_IDLE;
            r_mode   <= 3'd0;
            r_cutoff <= kvd_pkg::CUTOFF_RESET;
            r_count  <= '0;
            r_cur    <= '0;
        end else begin
            r_ui     <= n_ui;
            r_mode   <= n_mode;
            r_cutoff <= n_cutoff;
            r_count  <= n_count;
            r_cur    <= n_cur;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRY_DIGITS)) else $error("digit count beyond entry length");

    a_cmd_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_result.cmd_valid) |-> o_result.press_valid)
        else $error("command issued without a key press");

    a_enter_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_event.press && r_ui == kvd_pkg::UI_IDLE && fn == kvd_pkg::FN_B)
        |=> (r_ui == kvd_pkg::UI_SET && r_count == '0 && r_cur == '0))
        else $error("set key did not start a fresh entry");

endmodule

### design/keypad_debounce_value_entry.sv
// Top level of the keypad debounce and value entry block.
// One scan tick is taken per clock whenever full is low, and each tick gives exactly one result;
// a result reaches the result ports by way of the registered event queue and result queue.
// The debounce front end updates in the accepting cycle and hands a press event to a two-entry
// event queue; while the result queue has room, the entry machine retires one event per clock into
// a two-entry result queue, so the sustained rate is one tick per clock when pop keeps up. Either
// side may stall on its own: full rises once both queues have filled behind a stalled pop.
// There is no clearing pass after reset. Configuration writes take effect at the next edge.
module keypad_debounce_value_entry #(
    parameter int ENTRY_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  i_raw_key,
    output logic        empty,
    input  logic        pop,
    output logic        o_press_valid,
    output logic [3:0]  o_press_key,
    output logic        o_cmd_valid,
    output logic        o_cmd_kind,
    output logic [11:0] o_cmd_value,
    output logic        o_in_set_state,
    output logic [2:0]  o_filter_mode,
    output logic [11:0] o_cutoff_hz,
    output logic [2:0]  o_entry_len,
    output logic [13:0] o_entry_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);

    localparam int EW = $bits(kvd_pkg::t_event);
    localparam int RW = $bits(kvd_pkg::t_result);

    logic [7:0]         r_debounce;
    logic [11:0]        r_cutoff_min;
    logic [11:0]        r_cutoff_max;
    logic [3:0]         r_mode_count;

    logic               accept;
    kvd_pkg::t_event    fe_event;
    kvd_pkg::t_event    ev_head;
    logic               ev_full;
    logic               ev_empty;
    logic               ev_pop;
    logic               res_push;
    logic               res_full;
    kvd_pkg::t_result   res_in;
    kvd_pkg::t_result   res_head;
    kvd_pkg::t_back_cfg back_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= kvd_pkg::DEBOUNCE_RESET;
            r_cutoff_min <= kvd_pkg::CUTOFF_MIN_RESET;
            r_cutoff_max <= kvd_pkg::CUTOFF_MAX_RESET;
            r_mode_count <= kvd_pkg::MODE_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kvd_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[7:0];
                kvd_pkg::CFG_CUTOFF_MIN: r_cutoff_min <= i_cfg_data;
                kvd_pkg::CFG_CUTOFF_MAX: r_cutoff_max <= i_cfg_data;
                kvd_pkg::CFG_MODE_COUNT: r_mode_count <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign full   = ev_full;
    assign accept = push && !ev_full;

    assign back_cfg.cutoff_min = r_cutoff_min;
    assign back_cfg.cutoff_max = r_cutoff_max;
    assign back_cfg.mode_count = r_mode_count;

    kvd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_raw_key  (i_raw_key),
        .i_debounce (r_debounce),
        .o_event    (fe_event)
    );

    kvd_queue #(
        .WIDTH (EW)
    ) u_ev_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (fe_event),
        .i_pop   (ev_pop),
        .o_head  (ev_head),
        .o_full  (ev_full),
        .o_empty (ev_empty)
    );

    kvd_back #(
        .ENTRY_DIGITS (ENTRY_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (!ev_empty),
        .i_event     (ev_head),
        .i_out_ready (!res_full),
        .i_cfg       (back_cfg),
        .o_ev_pop    (ev_pop),
        .o_res_push  (res_push),
        .o_result    (res_in)
    );

    kvd_queue #(
        .WIDTH (RW)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_head  (res_head),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_press_valid  = res_head.press_valid;
    assign o_press_key    = res_head.press_key;
    assign o_cmd_valid    = res_head.cmd_valid;
    assign o_cmd_kind     = res_head.cmd_kind;
    assign o_cmd_value    = res_head.cmd_value;
    assign o_in_set_state = res_head.in_set_state;
    assign o_filter_mode  = res_head.filter_mode;
    assign o_cutoff_hz    = res_head.cutoff_hz;
    assign o_entry_len    = res_head.entry_len;
    assign o_entry_value  = res_head.entry_value;

endmodule

### dv/keypad_debounce_value_entry_test.sv
// Self-checking testbench for the keypad debounce and value entry block.
module keypad_debounce_value_entry_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRY_DIGITS = 4;

    localparam logic [4:0] KEY_A    = 5'd3;
    localparam logic [4:0] KEY_B    = 5'd7;
    localparam logic [4:0] KEY_C    = 5'd11;
    localparam logic [4:0] KEY_STAR = 5'd12;
    localparam logic [4:0] KEY_HASH = 5'd14;
    localparam logic [4:0] KEY_D    = 5'd15;

    // Key index of each decimal digit.
    localparam logic [4:0] DIGIT_KEY [10] = '{5'd13, 5'd0, 5'd1, 5'd2, 5'd4,
                                              5'd5, 5'd6, 5'd8, 5'd9, 5'd10};
    // Legend of each key index.
    localparam logic [3:0] LEGEND [16] = '{4'd1, 4'd2, 4'd3, kvd_pkg::FN_A, 4'd4, 4'd5, 4'd6,
                                           kvd_pkg::FN_B, 4'd7, 4'd8, 4'd9, kvd_pkg::FN_C,
                                           kvd_pkg::FN_STAR, 4'd0, kvd_pkg::FN_HASH,
                                           kvd_pkg::FN_D};

    localparam kvd_pkg::t_result AFTER_RESET = '{cutoff_hz: kvd_pkg::CUTOFF_RESET,
                                                 default: '0};
    localparam kvd_pkg::t_result MODE_WRAP   = '{press_valid: 1'b1, press_key: KEY_A[3:0],
                                                 cmd_valid: 1'b1, cmd_kind: kvd_pkg::CMD_MODE,
                                                 cutoff_hz: kvd_pkg::CUTOFF_RESET,
                                                 default: '0};

    typedef struct packed {
        bit               write;
        logic [1:0]       idx;
        logic [11:0]      data;
        logic [4:0]       scan;
        bit               known;
        kvd_pkg::t_result res;
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [4:0]  i_raw_key;
    logic        empty;
    logic        pop;
    logic        o_press_valid;
    logic [3:0]  o_press_key;
    logic        o_cmd_valid;
    logic        o_cmd_kind;
    logic [11:0] o_cmd_value;
    logic        o_in_set_state;
    logic [2:0]  o_filter_mode;
    logic [11:0] o_cutoff_hz;
    logic [2:0]  o_entry_len;
    logic [13:0] o_entry_value;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [11:0] i_cfg_data;

    // Predictor copy of the configuration and state.
    logic [7:0]         settle_ticks;
    logic [11:0]        clamp_lo;
    logic [11:0]        clamp_hi;
    logic [3:0]         mode_span;
    logic [4:0]         scan_prev;
    logic [4:0]         key_held;
    logic [7:0]         run_len;
    kvd_pkg::t_ui_state entry_state;
    logic [2:0]         mode_now;
    logic [11:0]        cutoff_now;
    logic [3:0]         digit_buf [ENTRY_DIGITS];
    int unsigned        digit_len;

    kvd_pkg::t_result pending_status [$];
    int unsigned      ticks_sent;
    int unsigned      mismatches;
    bit               steady;

    keypad_debounce_value_entry dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_raw_key      (i_raw_key),
        .empty          (empty),
        .pop            (pop),
        .o_press_valid  (o_press_valid),
        .o_press_key    (o_press_key),
        .o_cmd_valid    (o_cmd_valid),
        .o_cmd_kind     (o_cmd_kind),
        .o_cmd_value    (o_cmd_value),
        .o_in_set_state (o_in_set_state),
        .o_filter_mode  (o_filter_mode),
        .o_cutoff_hz    (o_cutoff_hz),
        .o_entry_len    (o_entry_len),
        .o_entry_value  (o_entry_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned entered_number();
        int unsigned v;
        v = 0;
        for (int i = 0; i < digit_len; i++) begin
            v = v * 10 + digit_buf[i];
        end
        return v;
    endfunction

    // Advances the predictor by one scan tick and returns the status it reports.
    function automatic kvd_pkg::t_result next_status(input logic [4:0] scan_in);
        kvd_pkg::t_result r;
        logic [4:0]       scan;
        logic [3:0]       fn;
        int unsigned      span;
        int unsigned      v;
        r = '0;
        scan = (scan_in > kvd_pkg::KEY_NONE) ? kvd_pkg::KEY_NONE : scan_in;
        if (scan == scan_prev) begin
            if (run_len != 8'd255) begin
                run_len++;
            end
        end else begin
            scan_prev = scan;
            run_len = '0;
        end
        if (run_len >= settle_ticks) begin
            if (scan != key_held) begin
                key_held = scan;
                if (scan != kvd_pkg::KEY_NONE) begin
                    r.press_valid = 1'b1;
                    r.press_key = scan[3:0];
                end
            end
            run_len = settle_ticks;
        end
        if (r.press_valid) begin
            fn = LEGEND[r.press_key];
            if (entry_state == kvd_pkg::UI_IDLE) begin
                if (fn == kvd_pkg::FN_A) begin
                    span = (mode_span == 0) ? 1 :
                           (mode_span > kvd_pkg::MODE_COUNT_MAX) ? 8 : mode_span;
                    mode_now = 3'((mode_now + 1) % span);
                    r.cmd_valid = 1'b1;
                    r.cmd_kind = kvd_pkg::CMD_MODE;
                    r.cmd_value = 12'(mode_now);
                end else if (fn == kvd_pkg::FN_B) begin
                    entry_state = kvd_pkg::UI_SET;
                    digit_len = 0;
                end
            end else if (fn <= kvd_pkg::FN_DIGIT_MAX) begin
                if (digit_len < ENTRY_DIGITS) begin
                    digit_buf[digit_len] = fn;
                    digit_len++;
                end
            end else if (fn == kvd_pkg::FN_STAR) begin
                if (digit_len > 0) begin
                    digit_len--;
                end
            end else if (fn == kvd_pkg::FN_HASH) begin
                if (digit_len > 0) begin
                    // The lower clamp goes first, so a minimum above the maximum yields the maximum.
                    v = entered_number();
                    if (v < clamp_lo) v = clamp_lo;
                    if (v > clamp_hi) v = clamp_hi;
                    cutoff_now = 12'(v);
                    r.cmd_valid = 1'b1;
                    r.cmd_kind = kvd_pkg::CMD_CUTOFF;
                    r.cmd_value = cutoff_now;
                end
                entry_state = kvd_pkg::UI_IDLE;
            end else if (fn == kvd_pkg::FN_D || fn == kvd_pkg::FN_B) begin
                entry_state = kvd_pkg::UI_IDLE;
            end
        end
        r.in_set_state = (entry_state == kvd_pkg::UI_SET);
        r.filter_mode = mode_now;
        r.cutoff_hz = cutoff_now;
        r.entry_len = 3'(digit_len);
        r.entry_value = 14'(entered_number());
        return r;
    endfunction

    function automatic t_step key_row(input logic [4:0] scan);
        t_step s;
        s = '0;
        s.scan = scan;
        return s;
    endfunction

    function automatic t_step known_row(input logic [4:0] scan, input kvd_pkg::t_result res);
        t_step s;
        s = key_row(scan);
        s.known = 1'b1;
        s.res = res;
        return s;
    endfunction

    function automatic t_step write_row(input logic [1:0] idx, input logic [11:0] data);
        t_step s;
        s = '0;
        s.write = 1'b1;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    task automatic send_tick(input logic [4:0] scan, input bit known,
                             input kvd_pkg::t_result res);
        kvd_pkg::t_result predicted;
        while (!steady && $urandom_range(0, 99) < 27) begin
            push <= 1'b0;
            i_raw_key <= 5'($urandom);
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_raw_key <= scan;
        do @(posedge i_clk); while (full);
        predicted = next_status(scan);
        pending_status.push_back(known ? res : predicted);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every status has come back and the pipeline has settled.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            kvd_pkg::CFG_DEBOUNCE:   settle_ticks = data[7:0];
            kvd_pkg::CFG_CUTOFF_MIN: clamp_lo = data;
            kvd_pkg::CFG_CUTOFF_MAX: clamp_hi = data;
            kvd_pkg::CFG_MODE_COUNT: mode_span = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // A clean press: held long enough to settle, then released long enough to settle.
    task automatic press(input logic [4:0] key);
        int unsigned hold;
        int unsigned gap;
        hold = settle_ticks + 1 + $urandom_range(0, (settle_ticks > 16) ? 40 : 2);
        gap = settle_ticks + 1 + $urandom_range(0, 2);
        repeat (hold) send_tick(key, 1'b0, '0);
        repeat (gap) send_tick(kvd_pkg::KEY_NONE, 1'b0, '0);
    endtask

    task automatic mismatch(input string field, input logic [13:0] want, input logic [13:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        pop <= steady || ($urandom_range(0, 99) >= 27);
    end

    always @(posedge i_clk) begin : check_status
        kvd_pkg::t_result want;
        kvd_pkg::t_result got;
        if (i_rst_n && pop && !empty) begin
            got = '{o_press_valid, o_press_key, o_cmd_valid, o_cmd_kind, o_cmd_value,
                    o_in_set_state, o_filter_mode, o_cutoff_hz, o_entry_len, o_entry_value};
            if (pending_status.size() == 0) begin
                $display("%0t: status transaction with nothing expected, got %p", $time, got);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                if (got.press_valid !== want.press_valid)
                    mismatch("press_valid", want.press_valid, got.press_valid);
                if (got.press_key !== want.press_key)
                    mismatch("press_key", want.press_key, got.press_key);
                if (got.cmd_valid !== want.cmd_valid)
                    mismatch("cmd_valid", want.cmd_valid, got.cmd_valid);
                if (got.cmd_kind !== want.cmd_kind)
                    mismatch("cmd_kind", want.cmd_kind, got.cmd_kind);
                if (got.cmd_value !== want.cmd_value)
                    mismatch("cmd_value", want.cmd_value, got.cmd_value);
                if (got.in_set_state !== want.in_set_state)
                    mismatch("in_set_state", want.in_set_state, got.in_set_state);
                if (got.filter_mode !== want.filter_mode)
                    mismatch("filter_mode", want.filter_mode, got.filter_mode);
                if (got.cutoff_hz !== want.cutoff_hz)
                    mismatch("cutoff_hz", want.cutoff_hz, got.cutoff_hz);
                if (got.entry_len !== want.entry_len)
                    mismatch("entry_len", want.entry_len, got.entry_len);
                if (got.entry_value !== want.entry_value)
                    mismatch("entry_value", want.entry_value, got.entry_value);
            end
        end
    end

    initial begin
        t_step       script [$];
        int unsigned target;
        int unsigned choice;
        logic [7:0]  deb;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [3:0]  span;
        push = 1'b0;
        pop = 1'b0;
        i_raw_key = kvd_pkg::KEY_NONE;
        i_cfg_we = 1'b0;
        i_cfg_idx = kvd_pkg::CFG_DEBOUNCE;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        steady = 1'b0;
        ticks_sent = 0;
        mismatches = 0;
        settle_ticks = kvd_pkg::DEBOUNCE_RESET;
        clamp_lo = kvd_pkg::CUTOFF_MIN_RESET;
        clamp_hi = kvd_pkg::CUTOFF_MAX_RESET;
        mode_span = kvd_pkg::MODE_COUNT_RESET;
        scan_prev = kvd_pkg::KEY_NONE;
        key_held = kvd_pkg::KEY_NONE;
        run_len = '0;
        entry_state = kvd_pkg::UI_IDLE;
        mode_now = '0;
        cutoff_now = kvd_pkg::CUTOFF_RESET;
        digit_len = 0;
        foreach (digit_buf[i]) digit_buf[i] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // With no debounce every change to a key is a press at once, which keeps this part short.
        script = '{
            known_row(kvd_pkg::KEY_NONE, AFTER_RESET),
            known_row(5'd31, AFTER_RESET),
            write_row(kvd_pkg::CFG_DEBOUNCE, 12'd0),
            write_row(kvd_pkg::CFG_MODE_COUNT, 12'd0),
            known_row(KEY_A, MODE_WRAP),
            key_row(kvd_pkg::KEY_NONE),
            write_row(kvd_pkg::CFG_MODE_COUNT, 12'd15),
            key_row(KEY_A),
            key_row(kvd_pkg::KEY_NONE),
            key_row(KEY_B),
            key_row(KEY_STAR),
            key_row(KEY_HASH),
            key_row(KEY_B),
            key_row(DIGIT_KEY[9]),
            key_row(DIGIT_KEY[8]),
            key_row(DIGIT_KEY[7]),
            key_row(DIGIT_KEY[0]),
            key_row(DIGIT_KEY[1]),
            key_row(KEY_STAR),
            key_row(DIGIT_KEY[4]),
            write_row(kvd_pkg::CFG_CUTOFF_MIN, 12'd4095),
            write_row(kvd_pkg::CFG_CUTOFF_MAX, 12'd0),
            key_row(KEY_HASH),
            key_row(KEY_C),
            key_row(KEY_D),
            key_row(KEY_B),
            key_row(KEY_D),
            key_row(KEY_B),
            key_row(kvd_pkg::KEY_NONE),
            key_row(KEY_B)
        };
        foreach (script[i]) begin
            if (script[i].write) begin
                wait_idle();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_tick(script[i].scan, script[i].known, script[i].res);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            deb = (phase == 5) ? 8'd255 : (phase == 1) ? 8'd0 : 8'($urandom_range(1, 4));
            lo = (phase == 0) ? 12'd0 : 12'($urandom_range(0, (phase == 7) ? 4095 : 400));
            hi = (phase == 0) ? 12'd4095 : 12'($urandom_range((phase == 7) ? 0 : 900, 4095));
            span = (phase == 0) ? 4'd8 : (phase == 1) ? 4'd1 : 4'($urandom_range(0, 15));
            write_reg(kvd_pkg::CFG_DEBOUNCE, 12'(deb));
            write_reg(kvd_pkg::CFG_CUTOFF_MIN, lo);
            write_reg(kvd_pkg::CFG_CUTOFF_MAX, hi);
            write_reg(kvd_pkg::CFG_MODE_COUNT, 12'(span));
            steady = (phase == 3) || (phase == 4);
            if (settle_ticks > 16) begin
                // Slow debounce: one long hold that settles and then saturates the run count.
                repeat (260) send_tick(KEY_A, 1'b0, '0);
            end else begin
                target = ticks_sent + 50;
                while (ticks_sent < target) begin
                    choice = $urandom_range(0, 99);
                    if (choice < 12) begin
                        repeat ($urandom_range(1, 6)) send_tick(5'($urandom), 1'b0, '0);
                    end else if (choice < 27) begin
                        repeat ($urandom_range(1, 3)) press(KEY_A);
                    end else if (choice < 87) begin
                        press(KEY_B);
                        repeat ($urandom_range(0, 5)) press(DIGIT_KEY[$urandom_range(0, 9)]);
                        if ($urandom_range(0, 2) == 0) begin
                            repeat ($urandom_range(1, 3)) press(KEY_STAR);
                            repeat ($urandom_range(0, 2)) press(DIGIT_KEY[$urandom_range(0, 9)]);
                        end
                        case ($urandom_range(0, 9))
                            0, 1: press(KEY_D);
                            2: press(KEY_B);
                            3: begin
                                press(KEY_C);
                                press(KEY_HASH);
                            end
                            default: press(KEY_HASH);
                        endcase
                    end else if (choice < 95) begin
                        press(5'($urandom_range(0, 15)));
                    end else begin
                        // A bounce that may be too short to settle.
                        repeat ($urandom_range(1, settle_ticks + 1))
                            send_tick(5'($urandom_range(0, 15)), 1'b0, '0);
                    end
                end
            end
        end

        push <= 1'b0;
        steady = 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### keypad_debounce_value_entry.f
design/kvd_pkg.sv
design/kvd_queue.sv
design/kvd_front.sv
design/kvd_back.sv
design/keypad_debounce_value_entry.sv
dv/keypad_debounce_value_entry_test.sv
